>>> hdl/min_tracking_stack_defines.svh
// Assertion macros shared by the min_tracking_stack checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define MTS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min_tracking_stack: assertion failed");

// next-cycle implication, disabled while rst is high
`define MTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min_tracking_stack: assertion failed");

`endif

>>> hdl/mts_pkg.sv
// Shared types, codes and sizes for the min_tracking_stack block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 8;

   // operation codes on req_func
   localparam logic [1:0] OP_PUSH       = 2'd0;
   localparam logic [1:0] OP_POP        = 2'd1;
   localparam logic [1:0] OP_REMOVE_MIN = 2'd2;

   // status codes on rsp_status
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // commands broadcast to every cell
   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_PUSH   = 3'd1;
   localparam logic [2:0] CMD_POP    = 3'd2;
   localparam logic [2:0] CMD_MARK   = 3'd3;
   localparam logic [2:0] CMD_BUBBLE = 3'd4;
   localparam logic [2:0] CMD_FIX    = 3'd5;

   typedef struct packed {
      logic [2:0]                op;
      logic [FILL_W-1:0]         fill;
      logic signed [VALUE_W-1:0] arg;   // pushed word or value to mark
   } mts_cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top_min;
      logic                      any_hole;
      logic                      bottom_hole;
   } mts_stat_type;

endpackage
`default_nettype wire

>>> hdl/mts_cell.sv
// One stack cell: an entry, the minimum of it and all deeper entries,
// and a hole flag used while compacting. Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mts_cell
   import mts_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mts_cmd_type               cmd,
   input  wire logic [FILL_W-1:0]         cell_index,
   input  wire logic signed [VALUE_W-1:0] up_value,
   input  wire logic signed [VALUE_W-1:0] up_min,
   input  wire logic                      up_hole,
   input  wire logic signed [VALUE_W-1:0] down_value,
   input  wire logic signed [VALUE_W-1:0] down_min,
   input  wire logic                      down_hole,
   input  wire logic                      down_live,
   output logic signed [VALUE_W-1:0]      value_out,
   output logic signed [VALUE_W-1:0]      min_out,
   output logic                           hole_out,
   output logic                           live_out,
   output logic                           bottom_hole
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic                      hole_ff, hole_in;
   logic                      live;

   // cell holds a live entry when its place is below the fill level
   assign live        = (cell_index < cmd.fill);
   assign value_out   = value_ff;
   assign min_out     = min_ff;
   assign hole_out    = hole_ff && live;
   assign live_out    = live;
   assign bottom_hole = hole_ff && live && !down_live;

   // next state per broadcast command
   always_comb begin
      value_in = value_ff;
      min_in   = min_ff;
      hole_in  = hole_ff;
      unique case (cmd.op)
         CMD_PUSH: begin
            if (cell_index == '0) begin
               value_in = cmd.arg;
               min_in   = (live && (min_ff < cmd.arg)) ? min_ff : cmd.arg;
            end else begin
               value_in = up_value;
               min_in   = up_min;
            end
         end
         CMD_POP: begin
            value_in = down_value;
            min_in   = down_min;
         end
         CMD_MARK: begin
            hole_in = live && (value_ff == cmd.arg);
         end
         CMD_BUBBLE: begin
            // a hole swaps with the live entry under it; entries keep order
            if (hole_ff && down_live && !down_hole) begin
               value_in = down_value;
               hole_in  = 1'b0;
            end else if (!hole_ff && live && up_hole) begin
               hole_in  = 1'b1;
            end
         end
         CMD_FIX: begin
            min_in = (down_live && (down_min < value_ff)) ? down_min : value_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      min_ff   <= min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff <= 1'b0;
      end else begin
         hole_ff <= hole_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/mts_chain.sv
// Row of STACK_DEPTH cells, top of stack at cell 0, wired to neighbors.
// Depends on mts_pkg and mts_cell.
`timescale 1ns / 1ps
`default_nettype none
module mts_chain
   import mts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mts_cmd_type cmd,
   output mts_stat_type     stat
);

   logic signed [VALUE_W-1:0] cell_value [STACK_DEPTH];
   logic signed [VALUE_W-1:0] cell_min   [STACK_DEPTH];
   logic [STACK_DEPTH-1:0]    cell_hole;
   logic [STACK_DEPTH-1:0]    cell_live;
   logic [STACK_DEPTH-1:0]    cell_bottom;

   genvar i;
   generate
      for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic signed [VALUE_W-1:0] up_value, up_min, down_value, down_min;
         logic                      up_hole, down_hole, down_live;

         // neighbor above (toward the top)
         if (i == 0) begin : g_top
            assign up_value = '0;
            assign up_min   = '0;
            assign up_hole  = 1'b0;
         end else begin : g_mid_up
            assign up_value = cell_value[i-1];
            assign up_min   = cell_min[i-1];
            assign up_hole  = cell_hole[i-1];
         end

         // neighbor below (toward the bottom)
         if (i == STACK_DEPTH - 1) begin : g_bot
            assign down_value = '0;
            assign down_min   = '0;
            assign down_hole  = 1'b0;
            assign down_live  = 1'b0;
         end else begin : g_mid_down
            assign down_value = cell_value[i+1];
            assign down_min   = cell_min[i+1];
            assign down_hole  = cell_hole[i+1];
            assign down_live  = cell_live[i+1];
         end

         mts_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .cell_index  (FILL_W'(i)),
            .up_value    (up_value),
            .up_min      (up_min),
            .up_hole     (up_hole),
            .down_value  (down_value),
            .down_min    (down_min),
            .down_hole   (down_hole),
            .down_live   (down_live),
            .value_out   (cell_value[i]),
            .min_out     (cell_min[i]),
            .hole_out    (cell_hole[i]),
            .live_out    (cell_live[i]),
            .bottom_hole (cell_bottom[i])
         );
      end
   endgenerate

   // status back to the sequencer
   assign stat.top_min     = cell_min[0];
   assign stat.any_hole    = |cell_hole;
   assign stat.bottom_hole = |cell_bottom;

endmodule
`default_nettype wire

>>> hdl/mts_ctrl.sv
// Sequencer: fill level, command broadcast, remove-lowest phases and the
// two-deep result path to the rsp port. Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mts_ctrl
   import mts_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_func,
   input  wire logic signed [VALUE_W-1:0] req_push_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_entry_count,
   output logic                           rsp_is_empty,
   output logic signed [VALUE_W-1:0]      rsp_lowest_value,
   output mts_cmd_type                    cmd,
   input  wire mts_stat_type              stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_BUBBLE = 2'd1;
   localparam logic [1:0] S_FIX    = 2'd2;
   localparam logic [1:0] S_REPORT = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [FILL_W-1:0]         cnt_ff, cnt_in;
   logic [1:0]                status_ff, status_in;

   // finished word waiting behind the output register
   logic                      slot_valid_ff, slot_valid_in;
   logic [1:0]                slot_status_ff;
   logic [COUNT_W-1:0]        slot_count_ff;
   logic                      slot_empty_ff;
   logic signed [VALUE_W-1:0] slot_lowest_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_empty_ff;
   logic signed [VALUE_W-1:0] rsp_lowest_ff;

   logic                      accept;
   logic                      move;
   logic                      is_full;
   logic                      is_zero;

   assign req_ready = (state_ff == S_IDLE) && !slot_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_full   = (fill_ff == FILL_W'(STACK_DEPTH));
   assign is_zero   = (fill_ff == '0);
   assign move      = slot_valid_ff && (!rsp_valid_ff || rsp_ready);

   // sequencing and command broadcast
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      cmd.op    = CMD_HOLD;
      cmd.fill  = fill_ff;
      cmd.arg   = req_push_value;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_REPORT;
               status_in = ST_DONE;
               unique case (req_func)
                  OP_PUSH: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.op  = CMD_PUSH;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.op  = CMD_POP;
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  OP_REMOVE_MIN: begin
                     if (is_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.op   = CMD_MARK;
                        cmd.arg  = stat.top_min;
                        state_in = S_BUBBLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BUBBLE: begin
            // holes sink one place a cycle; the bottom one is dropped
            cmd.op = CMD_BUBBLE;
            if (stat.bottom_hole) begin
               fill_in = fill_ff - 1'b1;
            end
            if (!stat.any_hole) begin
               cmd.op = CMD_HOLD;
               cnt_in = fill_ff;
               state_in = is_zero ? S_REPORT : S_FIX;
            end
         end
         S_FIX: begin
            // running minimum ripples up one cell a cycle
            cmd.op = CMD_FIX;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == FILL_W'(1)) begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result word handoff: slot then output register
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (state_ff == S_REPORT) begin
         slot_valid_in = 1'b1;
      end else if (move) begin
         slot_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         cnt_ff        <= '0;
         status_ff     <= ST_DONE;
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         cnt_ff        <= cnt_in;
         status_ff     <= status_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_REPORT) begin
         slot_status_ff <= status_ff;
         slot_count_ff  <= COUNT_W'(fill_ff);
         slot_empty_ff  <= is_zero;
         slot_lowest_ff <= is_zero ? '0 : stat.top_min;
      end
      if (move) begin
         rsp_status_ff <= slot_status_ff;
         rsp_count_ff  <= slot_count_ff;
         rsp_empty_ff  <= slot_empty_ff;
         rsp_lowest_ff <= slot_lowest_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_lowest_value = rsp_lowest_ff;

endmodule
`default_nettype wire

>>> hdl/min_tracking_stack.sv
// Top level of the min_tracking_stack block: sequencer plus cell chain.
// Depends on mts_pkg, mts_ctrl and mts_chain.
//
//   channel | ports                                     | dir
//   req     | req_valid/ready, req_func, req_push_value  | in
//   rsp     | rsp_valid/ready, rsp_status,              | out
//           | rsp_entry_count, rsp_is_empty, rsp_lowest_value
//
// Push, pop and unused codes pass from accept through the report state into a
// slot register, then into the output register. Remove-lowest: holes sink one
// cell a cycle, then the running minimum ripples up one cell a cycle.
// One item is worked at a time; a second may be accepted while the first
// word waits on a stalled rsp port. Reset is synchronous and leaves the
// stack empty; stored words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module min_tracking_stack
   import mts_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_func,
   input  wire logic signed [VALUE_W-1:0] req_push_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_W-1:0]             rsp_entry_count,
   output logic                           rsp_is_empty,
   output logic signed [VALUE_W-1:0]      rsp_lowest_value
);

   mts_cmd_type  cmd;
   mts_stat_type stat;

   // sequencer
   mts_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_lowest_value (rsp_lowest_value),
      .cmd              (cmd),
      .stat             (stat)
   );

   // storage cells
   mts_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule
`default_nettype wire

>>> hdl/min_tracking_stack_chk.sv
// Port-level checker for min_tracking_stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "min_tracking_stack_defines.svh"
module min_tracking_stack_chk
   import mts_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [1:0]                rsp_status,
   input wire logic [COUNT_W-1:0]        rsp_entry_count,
   input wire logic                      rsp_is_empty,
   input wire logic signed [VALUE_W-1:0] rsp_lowest_value
);

   // stalled word holds its payload
   `MTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_lowest_value) && $stable(rsp_entry_count) && $stable(rsp_status))

   // empty flag agrees with the count
   `MTS_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))

   // an empty stack reports zero as its lowest value
   `MTS_ASSERT_NOW(a_empty_lowest, clock, reset, rsp_valid && rsp_is_empty, rsp_lowest_value == '0)

   // nothing is offered right after reset
   `MTS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind min_tracking_stack min_tracking_stack_chk u_chk (.*);
`default_nettype wire
